@@ design/conv3_pkg.sv @@
`timescale 1ns / 1ps

package conv3_pkg;

  // Frame limits and coefficient format.
  localparam int MAX_W      = 2048;
  localparam int MAX_H      = 2048;
  localparam int COEFF_BITS = 8;

  // Field and counter widths.
  localparam int ADDR_W = $clog2(MAX_W);
  localparam int DIM_W  = 12;
  localparam int CNT_W  = 23;
  localparam int ACC_W  = 20;
  localparam int MAG_W  = 19;
  localparam int DIV_W  = 12;
  localparam int OFF_W  = 9;
  localparam int CFG_W  = 24;
  localparam int IDX_W  = 3;
  localparam int TAP_W  = 4;
  localparam int DCNT_W = 5;

  localparam int NUM_TAPS  = 9;
  localparam int DIV_STEPS = MAG_W;

  // Register indexes of the configuration port.
  localparam logic [IDX_W-1:0] REG_K_TOP    = 3'd0;
  localparam logic [IDX_W-1:0] REG_K_MID    = 3'd1;
  localparam logic [IDX_W-1:0] REG_K_BOT    = 3'd2;
  localparam logic [IDX_W-1:0] REG_DIVISOR  = 3'd3;
  localparam logic [IDX_W-1:0] REG_OFFSET   = 3'd4;
  localparam logic [IDX_W-1:0] REG_WIDTH    = 3'd5;
  localparam logic [IDX_W-1:0] REG_HEIGHT   = 3'd6;

  typedef logic [23:0] pixel_t;
  typedef logic signed [8:0] coeff_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADJ,
    ST_DEC,
    ST_SHIFT,
    ST_MAC,
    ST_DINIT,
    ST_DIV,
    ST_FIN
  } conv3_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic adjust;
    logic mem_rd;
    logic shift;
    logic mac_step;
    logic div_init;
    logic div_step;
    logic finish;
  } conv3_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic skip;
    logic emit;
    logic mac_last;
    logic div_last;
    logic out_free;
  } conv3_sts_t;

  // Window column of a tap; taps run column by column, top row first.
  function automatic logic [1:0] tap_col(input logic [TAP_W-1:0] t);
    logic [1:0] c;
    case (t)
      4'd0, 4'd1, 4'd2: c = 2'd0;
      4'd3, 4'd4, 4'd5: c = 2'd1;
      default:          c = 2'd2;
    endcase
    return c;
  endfunction

  // Window row of a tap.
  function automatic logic [1:0] tap_row(input logic [TAP_W-1:0] t);
    logic [1:0] r;
    case (t)
      4'd0, 4'd3, 4'd6: r = 2'd0;
      4'd1, 4'd4, 4'd7: r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  // Signed coefficient from the low bits of one byte of a kernel row.
  function automatic coeff_t get_coeff(input logic [CFG_W-1:0] krow, input logic [1:0] kc);
    logic [7:0] b;
    case (kc)
      2'd0:    b = krow[7:0];
      2'd1:    b = krow[15:8];
      default: b = krow[23:16];
    endcase
    return coeff_t'($signed(b[COEFF_BITS-1:0]));
  endfunction

endpackage

@@ design/conv3_in_if.sv @@
`timescale 1ns / 1ps

interface conv3_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;
  logic       drain;

  modport source (output valid, output in_red, output in_green, output in_blue,
                  output drain, input ready);
  modport sink   (input valid, input in_red, input in_green, input in_blue,
                  input drain, output ready);
endinterface

@@ design/conv3_out_if.sv @@
`timescale 1ns / 1ps

interface conv3_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       frame_end;

  modport source (output valid, output out_red, output out_green, output out_blue,
                  output frame_end, input ready);
  modport sink   (input valid, input out_red, input out_green, input out_blue,
                  input frame_end, output ready);
endinterface

@@ design/convolution_3x3_rgb.sv @@
`timescale 1ns / 1ps

// 3x3 convolution over an RGB raster stream. Each accepted word is one pixel
// in raster order, or a drain word once the whole frame is in; the result for
// a position leaves one row plus one pixel after its pixel went in, and
// image_width + 1 drain words flush the tail of the frame. Each pixel
// updates the counters and reads the line stores through their registered
// read port; one with a result then runs the multiply-accumulate (one
// kernel tap per cycle, three channel multipliers), the shared-step
// restoring division (one quotient bit per cycle over a 19-bit magnitude)
// and the load of the result register, which lets a finished word wait
// while the next pixel is taken. The user must write configuration only
// while the block is idle; the block itself does not enforce this.

module convolution_3x3_rgb import conv3_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  conv3_in_if.sink         in_i,
  conv3_out_if.source      out_o
);

  conv3_cmd_t cmd;
  conv3_sts_t sts;
  pixel_t     in_pix;
  pixel_t     out_pix;

  assign in_pix = {in_i.in_blue, in_i.in_green, in_i.in_red};

  // Sequencing.
  conv3_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Line stores, window and arithmetic.
  conv3_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_pix_i        (in_pix),
    .in_drain_i      (in_i.drain),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_ready_i     (out_o.ready),
    .out_valid_o     (out_o.valid),
    .out_pix_o       (out_pix),
    .out_frame_end_o (out_o.frame_end)
  );

  assign out_o.out_red   = out_pix[7:0];
  assign out_o.out_green = out_pix[15:8];
  assign out_o.out_blue  = out_pix[23:16];

endmodule

@@ design/conv3_ctrl.sv @@
`timescale 1ns / 1ps

module conv3_ctrl import conv3_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  conv3_sts_t sts_i,
  output conv3_cmd_t cmd_o
);

  conv3_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_ADJ;
        end
      end
      ST_ADJ: begin
        cmd_o.adjust = 1'b1;
        state_d      = ST_DEC;
      end
      ST_DEC: begin
        if (sts_i.skip) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.mem_rd = 1'b1;
          state_d      = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        cmd_o.shift = 1'b1;
        state_d     = sts_i.emit ? ST_MAC : ST_IDLE;
      end
      ST_MAC: begin
        cmd_o.mac_step = 1'b1;
        if (sts_i.mac_last) begin
          state_d = ST_DINIT;
        end
      end
      ST_DINIT: begin
        cmd_o.div_init = 1'b1;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ design/conv3_dp.sv @@
`timescale 1ns / 1ps

module conv3_dp import conv3_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  pixel_t           in_pix_i,
  input  logic             in_drain_i,
  input  conv3_cmd_t       cmd_i,
  output conv3_sts_t       sts_o,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output pixel_t           out_pix_o,
  output logic             out_frame_end_o
);

  // Configuration registers.
  logic [CFG_W-1:0] kern_q [3];
  logic [DIV_W-1:0] div_q;
  logic [OFF_W-1:0] off_q;
  logic [DIM_W-1:0] wcfg_q, hcfg_q;

  // Frame counters and products.
  logic [DIM_W-1:0]   col_q, row_q;
  logic [CNT_W-1:0]   cnt_q, wh_q;
  logic [DIM_W-1:0]   w_eff, h_eff;
  logic [2*DIM_W-1:0] wh_full;

  // Item, line stores and window.
  pixel_t pix_q;
  logic   drain_q;
  pixel_t mem_up_q [MAX_W];
  pixel_t mem_lo_q [MAX_W];
  pixel_t rd_up_q, rd_lo_q;
  pixel_t win_q [NUM_TAPS];

  // Per-output position information.
  logic ml_q, mr_q, mt_q, mb_q, fe_q;

  // Arithmetic state, one lane per color channel.
  logic [TAP_W-1:0]        tap_q;
  logic signed [ACC_W-1:0] acc_q [3];
  logic signed [ACC_W-1:0] acc_d [3];
  logic [MAG_W-1:0]        mag_q [3];
  logic [MAG_W-1:0]        mag_d [3];
  logic [DIV_W-1:0]        rem_q [3];
  logic [DIV_W-1:0]        rem_d [3];
  logic                    neg_q [3];
  logic [DCNT_W-1:0]       dcnt_q;

  logic             out_valid_q;
  pixel_t           out_pix_q;
  logic             out_fe_q;

  // Effective frame size and divisor.
  always_comb begin
    if (wcfg_q == '0) begin
      w_eff = DIM_W'(1);
    end else if (wcfg_q > DIM_W'(MAX_W)) begin
      w_eff = DIM_W'(MAX_W);
    end else begin
      w_eff = wcfg_q;
    end
    if (hcfg_q == '0) begin
      h_eff = DIM_W'(1);
    end else if (hcfg_q > DIM_W'(MAX_H)) begin
      h_eff = DIM_W'(MAX_H);
    end else begin
      h_eff = hcfg_q;
    end
  end

  assign wh_full = w_eff * h_eff;

  logic [DIV_W-1:0] dv;
  assign dv = (div_q == '0) ? DIV_W'(1) : div_q;

  // Counter wrap and frame restart ahead of the item.
  logic [DIM_W:0] col_w, row_w;
  logic           restart;
  always_comb begin
    if ({1'b0, col_q} >= {1'b0, w_eff}) begin
      col_w = '0;
      row_w = {1'b0, row_q} + (DIM_W+1)'(1);
    end else begin
      col_w = {1'b0, col_q};
      row_w = {1'b0, row_q};
    end
    restart = (row_w > {1'b0, h_eff} + (DIM_W+1)'(1)) || (cnt_q >= wh_q);
  end

  // Position decode for the output this item produces.
  logic             flush, emit, col_zero;
  logic [DIM_W-1:0] ccol, crow;
  logic [DIM_W:0]   col_nx;
  pixel_t           pix_in;
  always_comb begin
    flush    = row_q >= h_eff;
    col_zero = col_q == '0;
    emit     = (row_q >= DIM_W'(2)) || (row_q == DIM_W'(1) && !col_zero);
    ccol     = col_zero ? w_eff - DIM_W'(1) : col_q - DIM_W'(1);
    crow     = col_zero ? row_q - DIM_W'(2) : row_q - DIM_W'(1);
    col_nx   = {1'b0, col_q} + (DIM_W+1)'(1);
    pix_in   = flush ? '0 : pix_q;
  end

  // Multiply-accumulate over the taps, one tap per cycle.
  logic [1:0] kc, kr;
  coeff_t     coef;
  logic       tap_off;
  pixel_t     tap_px;
  logic signed [17:0] prod [3];
  always_comb begin
    kc      = tap_col(tap_q);
    kr      = tap_row(tap_q);
    coef    = get_coeff(kern_q[kr], kc);
    tap_px  = win_q[tap_q];
    tap_off = (kc == 2'd0 && ml_q) || (kc == 2'd2 && mr_q) ||
              (kr == 2'd0 && mt_q) || (kr == 2'd2 && mb_q);
    for (int c = 0; c < 3; c++) begin
      prod[c]  = $signed({1'b0, tap_px[8*c +: 8]}) * coef;
      acc_d[c] = acc_q[c] + (tap_off ? '0 : ACC_W'(prod[c]));
    end
  end

  // Restoring division step on the magnitude of each sum.
  logic [DIV_W:0] trial [3];
  logic [DIV_W:0] diff  [3];
  logic           ge    [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      trial[c] = {rem_q[c], mag_q[c][MAG_W-1]};
      diff[c]  = trial[c] - {1'b0, dv};
      ge[c]    = trial[c] >= {1'b0, dv};
      rem_d[c] = ge[c] ? diff[c][DIV_W-1:0] : trial[c][DIV_W-1:0];
      mag_d[c] = {mag_q[c][MAG_W-2:0], ge[c]};
    end
  end

  // Sign, offset and clamp.
  logic signed [MAG_W+1:0] qv  [3];
  logic signed [MAG_W+1:0] sv  [3];
  pixel_t                  res;
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      qv[c] = neg_q[c] ? -$signed({2'b00, mag_q[c]}) : $signed({2'b00, mag_q[c]});
      sv[c] = qv[c] + (MAG_W+2)'($signed(off_q));
      if (sv[c] < 0) begin
        res[8*c +: 8] = 8'd0;
      end else if (sv[c] > (MAG_W+2)'(255)) begin
        res[8*c +: 8] = 8'd255;
      end else begin
        res[8*c +: 8] = sv[c][7:0];
      end
    end
  end

  // Status to the controller.
  always_comb begin
    sts_o.skip     = !flush && drain_q;
    sts_o.emit     = emit;
    sts_o.mac_last = tap_q == TAP_W'(NUM_TAPS - 1);
    sts_o.div_last = dcnt_q == DCNT_W'(DIV_STEPS - 1);
    sts_o.out_free = !out_valid_q || out_ready_i;
  end

  // Configuration, counters, window shift and output handshake.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kern_q[0]   <= 24'h000000;
      kern_q[1]   <= 24'h010000;
      kern_q[2]   <= 24'h000000;
      div_q       <= DIV_W'(1);
      off_q       <= '0;
      wcfg_q      <= DIM_W'(640);
      hcfg_q      <= DIM_W'(480);
      col_q       <= '0;
      row_q       <= '0;
      cnt_q       <= '0;
      wh_q        <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_TAPS; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      wh_q <= wh_full[CNT_W-1:0];
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_K_TOP:   kern_q[0] <= cfg_data_i;
          REG_K_MID:   kern_q[1] <= cfg_data_i;
          REG_K_BOT:   kern_q[2] <= cfg_data_i;
          REG_DIVISOR: div_q     <= cfg_data_i[DIV_W-1:0];
          REG_OFFSET:  off_q     <= cfg_data_i[OFF_W-1:0];
          REG_WIDTH:   wcfg_q    <= cfg_data_i[DIM_W-1:0];
          REG_HEIGHT:  hcfg_q    <= cfg_data_i[DIM_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.adjust) begin
        if (restart) begin
          col_q <= '0;
          row_q <= '0;
          cnt_q <= '0;
        end else begin
          col_q <= col_w[DIM_W-1:0];
          row_q <= row_w[DIM_W-1:0];
        end
      end
      if (cmd_i.shift) begin
        for (int i = 0; i < 6; i++) begin
          win_q[i] <= win_q[i+3];
        end
        win_q[6] <= rd_up_q;
        win_q[7] <= rd_lo_q;
        win_q[8] <= pix_in;
        if (col_nx >= {1'b0, w_eff}) begin
          col_q <= '0;
          row_q <= row_q + DIM_W'(1);
        end else begin
          col_q <= col_nx[DIM_W-1:0];
        end
      end
      if (cmd_i.finish) begin
        if (fe_q) begin
          col_q <= '0;
          row_q <= '0;
          cnt_q <= '0;
        end else begin
          cnt_q <= cnt_q + CNT_W'(1);
        end
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Line stores: registered read, write back during the window shift.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_rd) begin
      rd_up_q <= mem_up_q[col_q[ADDR_W-1:0]];
      rd_lo_q <= mem_lo_q[col_q[ADDR_W-1:0]];
    end
    if (cmd_i.shift) begin
      mem_up_q[col_q[ADDR_W-1:0]] <= rd_lo_q;
      mem_lo_q[col_q[ADDR_W-1:0]] <= pix_in;
    end
  end

  // Item capture, position flags, arithmetic lanes and result word.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      pix_q   <= in_pix_i;
      drain_q <= in_drain_i;
    end
    if (cmd_i.shift) begin
      ml_q  <= ccol == '0;
      mr_q  <= col_zero;
      mt_q  <= crow == '0;
      mb_q  <= ({1'b0, crow} + (DIM_W+1)'(1)) >= {1'b0, h_eff};
      fe_q  <= (ccol == w_eff - DIM_W'(1)) && (crow == h_eff - DIM_W'(1));
      tap_q <= '0;
      for (int c = 0; c < 3; c++) begin
        acc_q[c] <= '0;
      end
    end
    if (cmd_i.mac_step) begin
      tap_q <= tap_q + TAP_W'(1);
      for (int c = 0; c < 3; c++) begin
        acc_q[c] <= acc_d[c];
      end
    end
    if (cmd_i.div_init) begin
      dcnt_q <= '0;
      for (int c = 0; c < 3; c++) begin
        neg_q[c] <= acc_q[c][ACC_W-1];
        mag_q[c] <= acc_q[c][ACC_W-1] ? MAG_W'(-acc_q[c]) : MAG_W'(acc_q[c]);
        rem_q[c] <= '0;
      end
    end
    if (cmd_i.div_step) begin
      dcnt_q <= dcnt_q + DCNT_W'(1);
      for (int c = 0; c < 3; c++) begin
        mag_q[c] <= mag_d[c];
        rem_q[c] <= rem_d[c];
      end
    end
    if (cmd_i.finish) begin
      out_pix_q <= res;
      out_fe_q  <= fe_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_pix_o       = out_pix_q;
  assign out_frame_end_o = out_fe_q;

endmodule

@@ design/conv3_chk.sv @@
`timescale 1ns / 1ps

module conv3_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue,
  input logic       frame_end
);

  // A stalled result word stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // A stalled result word keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable({out_red, out_green, out_blue, frame_end}))
    else $error("result word changed while stalled");

  // One pixel at a time: the input closes right after a word is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted a word while busy");

  // A new result never appears directly after an input word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared too early");

endmodule

bind convolution_3x3_rgb conv3_chk u_conv3_chk (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_red   (out_o.out_red),
  .out_green (out_o.out_green),
  .out_blue  (out_o.out_blue),
  .frame_end (out_o.frame_end)
);
